### sv/ckd_pkg.sv
// Shared types and constants for the keying envelope detector.
// No dependencies; every other file imports this package.
package ckd_pkg;

	// field widths
	localparam int PWR_W  = 32;
	localparam int NF_W   = 48;
	localparam int FAC_W  = 16;
	localparam int RUN_W  = 16;
	localparam int CNT_W  = 5;
	localparam int THR_W  = 64;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 48;

	// serial multiplier: wide operand times 16-bit operand, one bit per cycle
	localparam int MUL_AW = 64;
	localparam int MUL_BW = 16;
	localparam int MUL_CW = $clog2(MUL_BW);

	// register indexes
	localparam logic [CFG_IW-1:0] CFG_THR_MULT  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_HYST      = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_NF_START  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_FLUSH_CNT = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_IDLE_LIM  = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_RST_MIN   = 3'd5;

	// reset values
	localparam logic [FAC_W-1:0] THR_MULT_RST  = 16'd1280;
	localparam logic [FAC_W-1:0] HYST_RST      = 16'd45875;
	localparam logic [NF_W-1:0]  NF_RST        = 48'd66;
	localparam logic [CNT_W-1:0] FLUSH_CNT_RST = 5'd25;
	localparam logic [RUN_W-1:0] IDLE_LIM_RST  = 16'd300;
	localparam logic [CNT_W-1:0] RST_MIN_RST   = 5'd5;

	// floor tracking coefficients, Q0.16
	localparam logic [MUL_BW-1:0] K_TRACK = 16'd328;    // 0.005
	localparam logic [MUL_BW-1:0] K_OLD   = 16'd58982;  // 0.9
	localparam logic [MUL_BW-1:0] K_NEW   = 16'd6554;   // 0.1

	localparam logic [RUN_W-1:0] RUN_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [MUL_AW-1:0] hi;   // product >> 16
		logic [MUL_BW-1:0] lo;   // low 16 bits of product
	} mul_rsp_t;

endpackage

### sv/cw_key_envelope_detector.sv
// Keying envelope detector, top level: floor tracker, threshold test, run counter.
// Depends on ckd_pkg and ckd_sermul.
//
// Takes one power value per spectral frame for one channel and reports the length of
// each completed key-down (mark) or key-up (space) run, plus flush and idle-restart
// flags for the decoder downstream. Every product (floor tracking, floor blend,
// threshold, hysteresis) goes through one shared bit-serial multiplier that retires
// one multiplier bit per cycle. An item occupies the block from its input beat
// until it leaves S_FIN; a floor blend adds two products to the item and a key
// that is down adds one more, the hysteresis scaling of the threshold; the
// block takes no new input beat until then. A result waits in an output register, so
// the next item starts while it is unclaimed; only if that item also produces a result
// before the first is taken does the block hold, with in_stall high. The noise floor
// starts at 66 (Q32.16) after reset. A write to noise_floor_start is accepted but has
// no effect: the reset floor is fixed, so the block keeps no copy of it.
// Configuration writes are always ready and should only be made while no item is in
// flight and no result is pending.
module cw_key_envelope_detector import ckd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PWR_W-1:0]  power,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              run_valid,
	output logic              run_was_mark,
	output logic [RUN_W-1:0]  run_frames,
	output logic              flush,
	output logic              restart
);

	// sequencer codes
	localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for an input beat
	localparam logic [2:0] S_DIFF   = 3'd1;  // |ce - floor|, start tracking product
	localparam logic [2:0] S_TRACK  = 3'd2;  // floor +/- diff*0.005
	localparam logic [2:0] S_BLEND1 = 3'd3;  // floor*0.9
	localparam logic [2:0] S_BLEND2 = 3'd4;  // + ce*0.1
	localparam logic [2:0] S_TSTART = 3'd5;  // clamp floor, start threshold product
	localparam logic [2:0] S_THR    = 3'd6;  // threshold ready, maybe hysteresis
	localparam logic [2:0] S_FIN    = 3'd7;  // compare, update runs, emit

	logic [2:0]       state_q;
	logic [PWR_W-1:0] power_q;
	logic [NF_W-1:0]  nf_q;
	logic             ge_q;
	logic [NF_W-1:0]  hi1_q;
	logic [FAC_W-1:0] lo1_q;
	logic [THR_W-1:0] lim_q;
	logic             key_down_q;
	logic [RUN_W-1:0] run_len_q;
	logic [CNT_W-1:0] stored_q;
	logic             hys_q;     // limit still has to be scaled by hysteresis

	// configuration
	logic [FAC_W-1:0] thr_mult_q;
	logic [FAC_W-1:0] hyst_q;
	logic [CNT_W-1:0] flush_cnt_q;
	logic [RUN_W-1:0] idle_lim_q;
	logic [CNT_W-1:0] rst_min_q;

	// result register
	logic             out_valid_q;
	logic             run_valid_q;
	logic             run_mark_q;
	logic [RUN_W-1:0] run_frames_q;
	logic             flush_q;
	logic             restart_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	ckd_sermul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// datapath terms
	logic [NF_W-1:0]  ce;
	logic             ce_ge;
	logic [NF_W-1:0]  diff;
	logic [NF_W-1:0]  nf_track;
	logic             blend;
	logic [FAC_W:0]   lo_sum;
	logic [NF_W-1:0]  nf_blend;
	logic [NF_W-1:0]  nf_clamp;
	logic [THR_W-1:0] thr;
	logic             kd;

	assign ce       = {power_q, 16'd0};
	assign ce_ge    = ce >= nf_q;
	assign diff     = ce_ge ? (ce - nf_q) : (nf_q - ce);
	// rise rounds down, fall rounds up
	assign nf_track = ge_q ? (nf_q + mrsp.hi[NF_W-1:0])
		: (nf_q - (mrsp.hi[NF_W-1:0] + NF_W'(mrsp.lo != '0)));
	assign blend    = ce < nf_track;
	// (floor*0.9 + ce*0.1) >> 16 from the two split products
	assign lo_sum   = {1'b0, lo1_q} + {1'b0, mrsp.lo};
	assign nf_blend = hi1_q + mrsp.hi[NF_W-1:0] + NF_W'(lo_sum[FAC_W]);
	assign nf_clamp = (nf_q == '0) ? NF_W'(1) : nf_q;
	assign thr      = {mrsp.hi[NF_W-1:0], mrsp.lo};
	assign kd       = {8'd0, power_q, 24'd0} > lim_q;

	always_comb begin
		mreq.start = 1'b0;
		mreq.a     = {16'd0, diff};
		mreq.b     = K_TRACK;
		case (state_q)
			S_DIFF: begin
				mreq.start = 1'b1;
			end
			S_TRACK: begin
				mreq.start = mrsp.done && blend;
				mreq.a     = {16'd0, nf_track};
				mreq.b     = K_OLD;
			end
			S_BLEND1: begin
				mreq.start = mrsp.done;
				mreq.a     = {16'd0, ce};
				mreq.b     = K_NEW;
			end
			S_TSTART: begin
				mreq.start = 1'b1;
				mreq.a     = {16'd0, nf_clamp};
				mreq.b     = thr_mult_q;
			end
			S_THR: begin
				// hysteresis product only after the threshold one, key down
				mreq.start = mrsp.done && key_down_q && !hys_q;
				mreq.a     = thr;
				mreq.b     = hyst_q;
			end
			default: begin
			end
		endcase
	end

	// run bookkeeping for the frame just judged
	logic             change;
	logic [RUN_W-1:0] rl0, rl1, rl2;
	logic [CNT_W-1:0] sr0, sr1;
	logic             flush_cnt_hit;
	logic             idle_hit;
	logic             any_flush;
	logic             event_hit;
	logic             out_free;

	always_comb begin
		change        = kd != key_down_q;
		rl0           = change ? '0 : run_len_q;
		sr0           = stored_q;
		if (change && stored_q != CNT_MAX)
			sr0 = stored_q + 1'b1;
		rl1           = (rl0 == RUN_MAX) ? rl0 : rl0 + 1'b1;
		flush_cnt_hit = sr0 >= flush_cnt_q;
		sr1           = flush_cnt_hit ? '0 : sr0;
		rl2           = flush_cnt_hit ? '0 : rl1;
		idle_hit      = (rl2 >= idle_lim_q) && (sr1 >= rst_min_q);
		any_flush     = flush_cnt_hit || idle_hit;
		event_hit     = change || any_flush;
	end

	assign out_free = !out_valid_q || !out_stall;

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			nf_q       <= NF_RST;
			key_down_q <= 1'b0;
			run_len_q  <= '0;
			stored_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DIFF;
				end
				S_DIFF: begin
					state_q <= S_TRACK;
				end
				S_TRACK: begin
					if (mrsp.done) begin
						nf_q    <= nf_track;
						state_q <= blend ? S_BLEND1 : S_TSTART;
					end
				end
				S_BLEND1: begin
					if (mrsp.done)
						state_q <= S_BLEND2;
				end
				S_BLEND2: begin
					if (mrsp.done) begin
						nf_q    <= nf_blend;
						state_q <= S_TSTART;
					end
				end
				S_TSTART: begin
					nf_q    <= nf_clamp;
					state_q <= S_THR;
				end
				S_THR: begin
					// key up: threshold is the limit; key down: wait for the scaled one
					if (mrsp.done && (!key_down_q || hys_q))
						state_q <= S_FIN;
				end
				S_FIN: begin
					// with a result to emit, hold until the result register is free
					if (!event_hit || out_free) begin
						key_down_q <= kd;
						run_len_q  <= idle_hit ? '0 : rl2;
						stored_q   <= idle_hit ? '0 : sr1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			power_q <= power;
		if (state_q == S_DIFF)
			ge_q <= ce_ge;
		if (state_q == S_BLEND1 && mrsp.done) begin
			hi1_q <= mrsp.hi[NF_W-1:0];
			lo1_q <= mrsp.lo;
		end
		if (state_q == S_TSTART)
			hys_q <= 1'b0;
		if (state_q == S_THR && mrsp.done) begin
			if (hys_q)
				lim_q <= mrsp.hi;   // floor(thr * hyst / 2^16)
			else
				lim_q <= thr;
			hys_q <= key_down_q && !hys_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_mult_q  <= THR_MULT_RST;
			hyst_q      <= HYST_RST;
			flush_cnt_q <= FLUSH_CNT_RST;
			idle_lim_q  <= IDLE_LIM_RST;
			rst_min_q   <= RST_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THR_MULT:  thr_mult_q  <= cfg_data[FAC_W-1:0];
				CFG_HYST:      hyst_q      <= cfg_data[FAC_W-1:0];
				CFG_NF_START:  ;  // reset floor is fixed; nothing to hold
				CFG_FLUSH_CNT: flush_cnt_q <= cfg_data[CNT_W-1:0];
				CFG_IDLE_LIM:  idle_lim_q  <= cfg_data[RUN_W-1:0];
				CFG_RST_MIN:   rst_min_q   <= cfg_data[CNT_W-1:0];
				default:       ;
			endcase
		end
	end

	// result register: a new beat may load in the cycle the old one leaves
	wire load_out = (state_q == S_FIN) && event_hit && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			run_valid_q  <= change;
			run_mark_q   <= change && key_down_q;
			run_frames_q <= change ? run_len_q : '0;
			flush_q      <= any_flush;
			restart_q    <= idle_hit;
		end
	end

	assign cfg_ready    = 1'b1;
	assign in_stall     = state_q != S_IDLE;
	assign out_valid    = out_valid_q;
	assign run_valid    = run_valid_q;
	assign run_was_mark = run_mark_q;
	assign run_frames   = run_frames_q;
	assign flush        = flush_q;
	assign restart      = restart_q;

endmodule

### sv/ckd_sermul.sv
// Bit-serial shift-add multiplier, 64 x 16, right-shifting accumulator.
// Depends on ckd_pkg (widths, request and response structs).
module ckd_sermul import ckd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [MUL_CW-1:0] cnt_q;
	logic [MUL_AW-1:0] a_q;
	logic [MUL_AW-1:0] acc_q;
	logic [MUL_BW-1:0] b_q;
	logic [MUL_BW-1:0] lo_q;
	logic [MUL_AW:0]   sum;

	// one multiplier bit per cycle, LSB first; shifted-out bits form the low word
	assign sum = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CW'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
			lo_q  <= '0;
		end else if (busy_q) begin
			acc_q <= sum[MUL_AW:1];
			lo_q  <= {sum[0], lo_q[MUL_BW-1:1]};
			b_q   <= b_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.hi   = acc_q;
	assign rsp.lo   = lo_q;

endmodule

### sv/ckd_checker.sv
// Port-level checks for the keying envelope detector, bound to the top level.
// Depends on ckd_pkg (widths) and cw_key_envelope_detector (bind target).
module ckd_checker import ckd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic             run_valid,
	input logic             run_was_mark,
	input logic [RUN_W-1:0] run_frames,
	input logic             flush,
	input logic             restart
);

	// a result beat always reports a run or a flush
	a_beat_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_valid || flush))
		else $error("result beat with neither run nor flush");

	// a restart is always a flush, and run fields are zero without a run
	a_restart_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (restart || !run_valid)) |->
			((!restart || flush) && (run_valid || (!run_was_mark && run_frames == '0))))
		else $error("inconsistent result beat fields");

	// an accepted input beat keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again straight after an accept");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(run_valid)
			&& $stable(run_was_mark) && $stable(run_frames)
			&& $stable(flush) && $stable(restart)))
		else $error("stalled result beat changed");

endmodule

bind cw_key_envelope_detector ckd_checker u_ckd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.run_valid    (run_valid),
	.run_was_mark (run_was_mark),
	.run_frames   (run_frames),
	.flush        (flush),
	.restart      (restart)
);

### dv/tb_top.sv
// Self-checking bench for cw_key_envelope_detector: keying runs, flushes and idle restarts.
// Needs ckd_pkg (port widths, register indexes) and the detector RTL; nothing else.
`timescale 1ns / 100ps

module tb_top;
	import ckd_pkg::*;

	// ------------------------------------------------------------------
	// Bench constants
	// ------------------------------------------------------------------
	localparam int    WIDE_W      = 80;          // room for floor * factor * factor
	localparam int    REST_CYC    = 128;         // outlasts the slowest item
	localparam longint CYCLE_LIMIT = 1_000_000;  // several times the slowest whole run

	// unused register slots, written to prove they are ignored
	localparam logic [CFG_IW-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IW-1:0] CFG_SPARE_B = 3'd7;

	// floor tracking weights, Q0.16
	localparam logic [WIDE_W-1:0] TRACK_Q16 = 80'd328;    // 0.005 step toward power
	localparam logic [WIDE_W-1:0] OLD_Q16   = 80'd58982;  // 0.9 of old floor
	localparam logic [WIDE_W-1:0] NEW_Q16   = 80'd6554;   // 0.1 of new power
	localparam logic [WIDE_W-1:0] ROUND_Q16 = 80'd65535;  // ceiling on the way down

	localparam logic [RUN_W-1:0] RUN_FULL = 16'hFFFF;
	localparam logic [CNT_W-1:0] CNT_FULL = 5'd31;

	typedef struct packed {
		logic             run_valid;
		logic             run_was_mark;
		logic [RUN_W-1:0] run_frames;
		logic             flush;
		logic             restart;
	} run_report_t;

	localparam run_report_t NO_REPORT = '0;

	// directed rows: report typed in only where it is obvious by inspection
	typedef struct packed {
		logic [PWR_W-1:0] pwr;
		bit               pinned;
		bit               has;
		run_report_t      rep;
	} dir_row_t;

	localparam int DIR_ROWS = 22;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{32'h0000_0000, 1'b1, 1'b0, NO_REPORT},                    // quiet first frame
		'{32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b1, 1'b0, 16'd1, 1'b0, 1'b0}}, // key down, 1-frame space
		'{32'hFFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
		'{32'h0000_0000, 1'b1, 1'b1, '{1'b1, 1'b1, 16'd3, 1'b0, 1'b0}}, // key up, 3-frame mark
		'{32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
		'{32'h0000_0001, 1'b0, 1'b0, NO_REPORT},
		'{32'h8000_0000, 1'b0, 1'b0, NO_REPORT},
		'{32'h7FFF_FFFF, 1'b0, 1'b0, NO_REPORT},
		'{32'hAAAA_AAAA, 1'b0, 1'b0, NO_REPORT},
		'{32'h5555_5555, 1'b0, 1'b0, NO_REPORT},
		'{32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
		'{32'h0000_FFFF, 1'b0, 1'b0, NO_REPORT},
		'{32'h0001_0000, 1'b0, 1'b0, NO_REPORT},
		'{32'hFFFF_0000, 1'b0, 1'b0, NO_REPORT},
		'{32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
		'{32'h0000_0002, 1'b0, 1'b0, NO_REPORT},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
		'{32'hFFFF_FFFE, 1'b0, 1'b0, NO_REPORT},
		'{32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
		'{32'h0000_0001, 1'b0, 1'b0, NO_REPORT},
		'{32'h0000_0000, 1'b0, 1'b0, NO_REPORT}
	};

	// ------------------------------------------------------------------
	// DUT hookup; every input known from time zero
	// ------------------------------------------------------------------
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = CFG_THR_MULT;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [PWR_W-1:0]  power = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              run_valid;
	logic              run_was_mark;
	logic [RUN_W-1:0]  run_frames;
	logic              flush;
	logic              restart;

	cw_key_envelope_detector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.power        (power),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.run_valid    (run_valid),
		.run_was_mark (run_was_mark),
		.run_frames   (run_frames),
		.flush        (flush),
		.restart      (restart)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Keyer shadow: state and settings as they stand after reset.
	// The floor starts at 66 whatever is written to the start register,
	// since reset happens once only.
	// ------------------------------------------------------------------
	logic [NF_W-1:0]  kf_floor       = 48'd66;
	logic             kf_key         = 1'b0;
	logic [RUN_W-1:0] kf_run         = '0;
	logic [CNT_W-1:0] kf_stored      = '0;
	logic [FAC_W-1:0] kf_mult        = 16'd1280;
	logic [FAC_W-1:0] kf_hyst        = 16'd45875;
	logic [CNT_W-1:0] kf_flush_at    = 5'd25;
	logic [RUN_W-1:0] kf_idle_lim    = 16'd300;
	logic [CNT_W-1:0] kf_restart_min = 5'd5;

	run_report_t pending_reports [$];

	// typed-in expectation for the beat being offered
	bit          pin_on  = 1'b0;
	bit          pin_has = 1'b0;
	run_report_t pin_rep = '0;

	bit gap_on   = 1'b0;
	bit stall_on = 1'b0;

	int     n_err      = 0;
	int     n_frames   = 0;
	int     n_runs     = 0;
	int     n_sat      = 0;
	int     n_flush    = 0;
	int     n_restart  = 0;
	int     stall_left = 0;
	longint cyc        = 0;

	// One frame through the keyer: floor update, threshold test, run book-keeping.
	task automatic advance_keyer(input logic [PWR_W-1:0] p, output bit has,
			output run_report_t rep);
		logic [WIDE_W-1:0] ce, nf, thr, p24;
		bit kd;
		ce  = {48'd0, p} << 16;   // Q32.16
		p24 = {48'd0, p} << 24;   // Q40.24, same scale as thr
		nf  = {32'd0, kf_floor};
		// slow follow, rounded so the floor always moves when falling
		if (ce >= nf)
			nf = nf + (((ce - nf) * TRACK_Q16) >> 16);
		else
			nf = nf - ((((nf - ce) * TRACK_Q16) + ROUND_Q16) >> 16);
		// fast pull-down when still above the power
		if (ce < nf)
			nf = ((nf * OLD_Q16) + (ce * NEW_Q16)) >> 16;
		if (nf == '0)
			nf = WIDE_W'(1);
		kf_floor = nf[NF_W-1:0];
		thr = nf * {64'd0, kf_mult};
		if (kf_key)
			kd = p24 > ((thr * {64'd0, kf_hyst}) >> 16);
		else
			kd = p24 > thr;

		rep = '0;
		if (kd != kf_key) begin
			rep.run_valid    = 1'b1;
			rep.run_was_mark = kf_key;
			rep.run_frames   = kf_run;
			if (kf_stored != CNT_FULL)
				kf_stored++;
			kf_key = kd;
			kf_run = '0;
		end
		if (kf_run != RUN_FULL)
			kf_run++;
		if (kf_stored >= kf_flush_at) begin
			rep.flush = 1'b1;
			kf_stored = '0;
			kf_run    = '0;
		end
		// idle restart may follow a count flush in the same frame
		if (kf_run >= kf_idle_lim && kf_stored >= kf_restart_min) begin
			rep.flush   = 1'b1;
			rep.restart = 1'b1;
			kf_stored   = '0;
			kf_run      = '0;
		end
		has = rep.run_valid || rep.flush;
	endtask

	// ------------------------------------------------------------------
	// Scoreboard: results checked against the oldest expectation first,
	// then any input beat on this edge is run through the shadow.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		bit          has;
		run_report_t rep, got, want;
		if (out_valid && !out_stall) begin
			got = {run_valid, run_was_mark, run_frames, flush, restart};
			if (pending_reports.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("%0t: unexpected report run=%0b mark=%0b frames=%0d ",
						$time, got.run_valid, got.run_was_mark, got.run_frames,
						"flush=%0b restart=%0b", got.flush, got.restart);
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					n_err++;
					if (n_err <= 10)
						$display("%0t: report mismatch, want run=%0b mark=%0b ",
							$time, want.run_valid, want.run_was_mark,
							"frames=%0d flush=%0b restart=%0b", want.run_frames,
							want.flush, want.restart,
							" / got run=%0b mark=%0b frames=%0d flush=%0b restart=%0b",
							got.run_valid, got.run_was_mark, got.run_frames,
							got.flush, got.restart);
				end
			end
			if (got.run_valid)
				n_runs++;
			if (got.run_valid && got.run_frames == RUN_FULL)
				n_sat++;
			if (got.flush)
				n_flush++;
			if (got.restart)
				n_restart++;
		end
		if (in_valid && !in_stall) begin
			advance_keyer(power, has, rep);
			if (pin_on) begin
				has = pin_has;
				rep = pin_rep;
			end
			if (has)
				pending_reports = {pending_reports, rep};
			n_frames++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("cw_key_envelope_detector verification failed");
			$finish;
		end
	end

	// Receiver back-pressure: random stall bursts while stall_on is set
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (stall_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 19);
		end
	end

	// ------------------------------------------------------------------
	// Driver tasks
	// ------------------------------------------------------------------

	// Offer one power beat, optionally after idle bursts, and hold it until taken.
	task automatic push_power(input logic [PWR_W-1:0] p, input bit pinned, input bit p_has,
			input run_report_t p_rep);
		while (gap_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 18)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		power    <= p;
		pin_on  = pinned;
		pin_has = p_has;
		pin_rep = p_rep;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering, let every expected report out, then allow for a
	// frame still in flight that reports nothing.
	task automatic drain_and_rest();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (REST_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_THR_MULT:  kf_mult        = val[FAC_W-1:0];
			CFG_HYST:      kf_hyst        = val[FAC_W-1:0];
			CFG_FLUSH_CNT: kf_flush_at    = val[CNT_W-1:0];
			CFG_IDLE_LIM:  kf_idle_lim    = val[RUN_W-1:0];
			CFG_RST_MIN:   kf_restart_min = val[CNT_W-1:0];
			default: ;     // start floor write has no effect; spare slots ignored
		endcase
	endtask

	// Full register set for one phase; unused upper data bits carry noise.
	task automatic configure(input logic [FAC_W-1:0] mult, input logic [FAC_W-1:0] hyst,
			input logic [NF_W-1:0] nf_start, input logic [CNT_W-1:0] flush_at,
			input logic [RUN_W-1:0] idle_lim, input logic [CNT_W-1:0] restart_min,
			input bit spares);
		logic [CFG_DW-1:0] junk;
		drain_and_rest();
		junk[31:0]  = $urandom;
		junk[47:32] = 16'($urandom_range(0, 16'hFFFF));
		write_reg(CFG_THR_MULT,  {junk[47:16], mult});
		write_reg(CFG_HYST,      {junk[47:16], hyst});
		write_reg(CFG_NF_START,  nf_start);
		write_reg(CFG_FLUSH_CNT, {junk[47:5], flush_at});
		write_reg(CFG_IDLE_LIM,  {junk[47:16], idle_lim});
		write_reg(CFG_RST_MIN,   {junk[47:5], restart_min});
		if (spares) begin
			write_reg(CFG_SPARE_A, {junk[15:0], $urandom});
			write_reg(CFG_SPARE_B, '1);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly keyed sequences (alternating mark/space runs over a noise
	// level, now and then a long mark or space for the idle restart), the rest
	// stray frames and extremes.
	task automatic play_keying(input int n);
		int  left, noise, runs, len, gain, sh;
		bit  mark;
		logic [PWR_W-1:0] lvl;
		left = n;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0: begin
					push_power($urandom, 1'b0, 1'b0, NO_REPORT);
					left--;
				end
				1: begin
					case ($urandom_range(0, 2))
						0:       lvl = '0;
						1:       lvl = '1;
						default: lvl = 32'd1 << $urandom_range(0, 31);
					endcase
					push_power(lvl, 1'b0, 1'b0, NO_REPORT);
					left--;
				end
				default: begin
					noise = $urandom_range(0, 3000);
					mark  = 1'($urandom_range(0, 1));
					runs  = $urandom_range(2, 14);
					for (int r = 0; r < runs && left > 0; r++) begin
						len  = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 80)
						                                   : $urandom_range(1, 12);
						gain = $urandom_range(30, 300);
						sh   = $urandom_range(0, 10);
						for (int f = 0; f < len && left > 0; f++) begin
							if (mark)
								lvl = ((noise + 1) * gain + $urandom_range(0, noise)) << sh;
							else
								lvl = $urandom_range(0, noise);
							push_power(lvl, 1'b0, 1'b0, NO_REPORT);
							left--;
						end
						mark = !mark;
					end
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed frames at reset settings, with output stalls
		stall_on = 1'b1;
		for (int i = 0; i < DIR_ROWS; i++)
			push_power(DIR_TAB[i].pwr, DIR_TAB[i].pinned, DIR_TAB[i].has, DIR_TAB[i].rep);

		// reset-like settings, zero start floor written (no effect)
		configure(16'd1280, 16'd45875, 48'd0, 5'd25, 16'd300, 5'd5, 1'b0);
		gap_on = 1'b1;
		play_keying(150);

		// lowest factors, flush count and idle limit zero: flush and restart every frame
		configure(16'd1, 16'd0, 48'hFFFF_FFFF_FFFF, 5'd0, 16'd0, 5'd0, 1'b1);
		play_keying(80);

		// highest factors and limits
		configure(16'hFFFF, 16'hFFFF, 48'd1, 5'd31, 16'hFFFF, 5'd31, 1'b0);
		gap_on = 1'b0;
		play_keying(100);

		// short flush and idle windows so both fire often
		configure(16'd768, 16'd49152, 48'd66, 5'd6, 16'd12, 5'd2, 1'b1);
		gap_on = 1'b1;
		play_keying(150);

		// random settings, a stretch with no idling on either side
		configure(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
			NF_W'($urandom), 5'($urandom_range(1, 31)), 16'($urandom_range(4, 40)),
			5'($urandom_range(0, 31)), 1'b0);
		gap_on   = 1'b0;
		stall_on = 1'b0;
		play_keying(150);

		// zero idle limit with a modest restart floor
		configure(16'd512, 16'd32768, 48'd1000, 5'd10, 16'd0, 5'd3, 1'b0);
		gap_on   = 1'b1;
		stall_on = 1'b1;
		play_keying(100);

		configure(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
			NF_W'($urandom), 5'($urandom_range(1, 31)), 16'($urandom_range(4, 40)),
			5'($urandom_range(0, 31)), 1'b1);
		play_keying(150);

		// closing stretch at full rate, no idling on either side
		gap_on   = 1'b0;
		stall_on = 1'b0;
		configure(16'd1024, 16'd52000, 48'd66, 5'd12, 16'd20, 5'd4, 1'b0);
		play_keying(150);

		drain_and_rest();

		$display("Drove %0d frames over nine register settings: %0d runs reported",
			n_frames, n_runs, " (%0d at full count), %0d flushes, %0d idle restarts",
			n_sat, n_flush, n_restart);
		if (n_err == 0)
			$display("cw_key_envelope_detector verification clean");
		else
			$display("cw_key_envelope_detector verification failed");
		$finish;
	end

endmodule
